### src/box_filter_3x3_edge_average_macros.svh
`ifndef BOX_FILTER_3X3_EDGE_AVERAGE_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AVERAGE_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define BFA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define BFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/bfa_pkg.sv
package bfa_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 13;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;

  // Row counters must reach height + 1 while draining
  localparam int ROW_W = 13;
  localparam logic [ROW_W-1:0] HEIGHT_LIMIT = 13'd4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

  // Input item kinds
  localparam logic KIND_PIXEL = 1'b0;

  // Number of in-image neighbors averaged
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_ONE   = 4'd1;
  localparam logic [CNT_W-1:0] CNT_TWO   = 4'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 4'd3;
  localparam logic [CNT_W-1:0] CNT_FOUR  = 4'd4;
  localparam logic [CNT_W-1:0] CNT_SIX   = 4'd6;
  localparam logic [CNT_W-1:0] CNT_NINE  = 4'd9;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // Per-item control that follows a pixel down the pipeline
  typedef struct packed {
    logic       emit;
    logic [2:0] row_mask;
    logic [2:0] col_mask;
    logic       last;
  } bfa_tag_t;

endpackage

### src/bfa_ifs.sv
interface bfa_in_if #(
  parameter int PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, kind, pixel_value, input ready);
  modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface bfa_out_if #(
  parameter int PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] smoothed_value;
  logic                  end_of_image;

  modport source (output valid, smoothed_value, end_of_image, input ready);
  modport sink   (input valid, smoothed_value, end_of_image, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/bfa_ram.sv
module bfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bfa_ctrl.sv
`include "box_filter_3x3_edge_average_macros.svh"

module bfa_ctrl import bfa_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WREG_W = $clog2(MAX_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bfa_cfg_if.sink               cfg_i,
  bfa_in_if.sink                pix_i,
  input  logic                  credit_ok_i,
  output logic                  rd_en_o,
  output logic [COL_W-1:0]      rd_addr_o,
  output logic                  s1_valid_o,
  output logic [PIXEL_BITS-1:0] s1_pix_o,
  output logic [COL_W-1:0]      s1_col_o,
  output bfa_tag_t              s1_tag_o,
  output logic                  reserve_o
);

  logic [WREG_W-1:0] w_q, w_d;
  logic [ROW_W-1:0]  h_q, h_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;

  logic                  s1_valid_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [COL_W-1:0]      s1_col_q;
  bfa_tag_t              s1_tag_q, tag;

  logic                      accept, cfg_wr;
  logic                      received, shift_pix, shift_zero, shift, emit, last;
  logic                      in_col_end, out_col_end, out_row_end;
  logic [WREG_W-1:0]         w_m1, w_sat;
  logic [ROW_W-1:0]          h_sat;
  logic [WIDTH_FIELD_W-1:0]  wfield;
  logic [HEIGHT_FIELD_W-1:0] hfield;

  assign pix_i.ready = credit_ok_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = pix_i.valid && pix_i.ready;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  // Position decode
  assign w_m1        = w_q - WREG_W'(1);
  assign in_col_end  = (WREG_W'(in_col_q) == w_m1);
  assign out_col_end = (WREG_W'(out_col_q) == w_m1);
  assign out_row_end = (out_row_q == h_q - ROW_W'(1));
  assign received    = (in_row_q >= h_q);
  assign shift_pix   = (pix_i.kind == KIND_PIXEL) && !received;
  assign shift_zero  = received && (out_row_q < h_q);
  assign shift       = accept && (shift_pix || shift_zero);
  // A result is due once one row plus one column has been taken in
  assign emit        = (in_row_q >= ROW_W'(2)) ||
                       ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign last        = out_row_end && out_col_end;

  // Clamp register writes into the legal range
  assign wfield = cfg_i.data[WIDTH_FIELD_W-1:0];
  assign hfield = cfg_i.data[HEIGHT_FIELD_W-1:0];

  always_comb begin
    if (wfield == '0) begin
      w_sat = WREG_W'(1);
    end else if (32'(wfield) > MAX_WIDTH) begin
      w_sat = WREG_W'(MAX_WIDTH);
    end else begin
      w_sat = WREG_W'(wfield);
    end
    if (hfield == '0) begin
      h_sat = ROW_W'(1);
    end else if (ROW_W'(hfield) > HEIGHT_LIMIT) begin
      h_sat = HEIGHT_LIMIT;
    end else begin
      h_sat = ROW_W'(hfield);
    end
  end

  // Advance input and output positions
  always_comb begin
    w_d       = w_q;
    h_d       = h_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_wr) begin
      unique case (cfg_i.index)
        CFG_IMAGE_WIDTH: begin
          w_d       = w_sat;
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
        CFG_IMAGE_HEIGHT: begin
          h_d       = h_sat;
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
        default: begin
        end
      endcase
    end else if (shift) begin
      if (in_col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  // Neighborhood masks for the output position
  always_comb begin
    tag.emit     = emit;
    tag.row_mask = {!out_row_end, 1'b1, out_row_q != '0};
    tag.col_mask = {!out_col_end, 1'b1, out_col_q != '0};
    tag.last     = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= WREG_W'(1);
      h_q        <= ROW_W'(1);
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      w_q        <= w_d;
      h_q        <= h_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      s1_valid_q <= shift;
    end
  end

  // Hand the beat to the line store stage
  always_ff @(posedge clk_i) begin
    if (shift) begin
      s1_pix_q <= shift_pix ? pix_i.pixel_value : '0;
      s1_col_q <= in_col_q;
      s1_tag_q <= tag;
    end
  end

  assign rd_en_o    = shift;
  assign rd_addr_o  = in_col_q;
  assign s1_valid_o = s1_valid_q;
  assign s1_pix_o   = s1_pix_q;
  assign s1_col_o   = s1_col_q;
  assign s1_tag_o   = s1_tag_q;
  assign reserve_o  = shift && emit;

  `BFA_ASSERT_ALWAYS(a_in_col_range, clk_i, rst_ni, WREG_W'(in_col_q) < w_q, "input column past width")
  `BFA_ASSERT_ALWAYS(a_out_row_range, clk_i, rst_ni, out_row_q < h_q, "output row past height")

endmodule

### src/bfa_window.sv
module bfa_window import bfa_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [COL_W-1:0]           rd_addr_i,
  input  logic                       s1_valid_i,
  input  logic [PIXEL_BITS-1:0]      s1_pix_i,
  input  logic [COL_W-1:0]           s1_col_i,
  input  bfa_tag_t                   s1_tag_i,
  output logic [8:0][PIXEL_BITS-1:0] win_o,
  output logic                       s2_valid_o,
  output bfa_tag_t                   s2_tag_o
);

  localparam int LINE_W = 2 * PIXEL_BITS;

  logic [LINE_W-1:0]             ram_rdata, rd_eff, wr_data;
  logic [LINE_W-1:0]             fwd_data_q;
  logic                          fwd_q, fwd_d;
  logic [PIXEL_BITS-1:0]         up, lo;
  logic [8:0][PIXEL_BITS-1:0]    win_q, win_d;
  logic                          s2_valid_q;
  bfa_tag_t                      s2_tag_q;

  // Upper line in the high half, lower line in the low half
  bfa_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_i),
    .waddr_i (s1_col_i),
    .wdata_i (wr_data),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // Bypass the store when the next beat reads the column being written
  assign fwd_d   = rd_en_i && s1_valid_i && (rd_addr_i == s1_col_i);
  assign rd_eff  = fwd_q ? fwd_data_q : ram_rdata;
  assign up      = rd_eff[LINE_W-1:PIXEL_BITS];
  assign lo      = rd_eff[PIXEL_BITS-1:0];
  assign wr_data = {lo, s1_pix_i};

  // Shift the window one column left and load the new column
  always_comb begin
    win_d = win_q;
    if (s1_valid_i) begin
      for (int q = 0; q < 3; q++) begin
        win_d[q*3+0] = win_q[q*3+1];
        win_d[q*3+1] = win_q[q*3+2];
      end
      win_d[2] = up;
      win_d[5] = lo;
      win_d[8] = s1_pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      fwd_q      <= fwd_d;
      win_q      <= win_d;
      s2_valid_q <= s1_valid_i && s1_tag_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
    s2_tag_q   <= s1_tag_i;
  end

  assign win_o      = win_q;
  assign s2_valid_o = s2_valid_q;
  assign s2_tag_o   = s2_tag_q;

endmodule

### src/bfa_mean.sv
module bfa_mean import bfa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [8:0][PIXEL_BITS-1:0] win_i,
  input  logic                       s2_valid_i,
  input  bfa_tag_t                   s2_tag_i,
  output logic                       push_o,
  output logic [PIXEL_BITS-1:0]      push_value_o,
  output logic                       push_last_o
);

  // Sum of nine pixels, and a reciprocal exact for every such sum
  localparam int SUM_W      = PIXEL_BITS + 4;
  localparam int DivShift   = SUM_W + 4;
  localparam int RECIP_W    = DivShift + 1;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int RecipOne   = 2 ** DivShift;
  localparam int RecipTwo   = (2 ** DivShift + 1) / 2;
  localparam int RecipThree = (2 ** DivShift + 2) / 3;
  localparam int RecipFour  = (2 ** DivShift + 3) / 4;
  localparam int RecipSix   = (2 ** DivShift + 5) / 6;
  localparam int RecipNine  = (2 ** DivShift + 8) / 9;

  logic [SUM_W-1:0]   sum_d, s3_sum_q;
  logic [1:0]         row_n, col_n;
  logic [CNT_W-1:0]   cnt_d, s3_cnt_q;
  logic               s3_valid_q, s3_last_q;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  // Add the in-image pixels of the window
  always_comb begin
    sum_d = '0;
    for (int q = 0; q < 3; q++) begin
      for (int s = 0; s < 3; s++) begin
        if (s2_tag_i.row_mask[q] && s2_tag_i.col_mask[s]) begin
          sum_d = sum_d + SUM_W'(win_i[q*3+s]);
        end
      end
    end
  end

  assign row_n = {1'b0, s2_tag_i.row_mask[0]} + {1'b0, s2_tag_i.row_mask[1]} +
                 {1'b0, s2_tag_i.row_mask[2]};
  assign col_n = {1'b0, s2_tag_i.col_mask[0]} + {1'b0, s2_tag_i.col_mask[1]} +
                 {1'b0, s2_tag_i.col_mask[2]};
  assign cnt_d = {2'b00, row_n} * {2'b00, col_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sum_q  <= sum_d;
    s3_cnt_q  <= cnt_d;
    s3_last_q <= s2_tag_i.last;
  end

  // Divide by the neighbor count through its reciprocal
  always_comb begin
    case (s3_cnt_q)
      CNT_ONE:   recip = RECIP_W'(RecipOne);
      CNT_TWO:   recip = RECIP_W'(RecipTwo);
      CNT_THREE: recip = RECIP_W'(RecipThree);
      CNT_FOUR:  recip = RECIP_W'(RecipFour);
      CNT_SIX:   recip = RECIP_W'(RecipSix);
      CNT_NINE:  recip = RECIP_W'(RecipNine);
      default:   recip = RECIP_W'(RecipOne);
    endcase
  end

  assign prod         = PROD_W'(s3_sum_q) * PROD_W'(recip);
  assign push_o       = s3_valid_q;
  assign push_value_o = prod[DivShift +: PIXEL_BITS];
  assign push_last_o  = s3_last_q;

endmodule

### src/bfa_ofifo.sv
`include "box_filter_3x3_edge_average_macros.svh"

module bfa_ofifo import bfa_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [PIXEL_BITS-1:0] push_value_i,
  input  logic                  push_last_i,
  input  logic                  reserve_i,
  output logic                  credit_ok_o,
  bfa_out_if.source             res_o
);

  logic [PIXEL_BITS:0]     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   cnt_q, cnt_d, res_q, res_d;
  logic                    pop;

  assign pop = res_o.valid && res_o.ready;

  // Reserve a slot per accepted result-bearing beat; release on pop
  assign res_d       = res_q + FIFO_CNT_W'(reserve_i) - FIFO_CNT_W'(pop);
  assign cnt_d       = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop);
  assign credit_ok_o = (res_q < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      res_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= {push_last_i, push_value_i};
    end
  end

  assign res_o.valid          = (cnt_q != '0);
  assign res_o.smoothed_value = mem_q[rd_ptr_q][PIXEL_BITS-1:0];
  assign res_o.end_of_image   = mem_q[rd_ptr_q][PIXEL_BITS];

  `BFA_ASSERT_ALWAYS(a_res_bound, clk_i, rst_ni, res_q <= FIFO_CNT_W'(FIFO_DEPTH), "reservations exceed depth")
  `BFA_ASSERT_IMPLY(a_push_reserved, clk_i, rst_ni, push_i, res_q > cnt_q, "push without reserved slot")

endmodule

### src/box_filter_3x3_edge_average.sv
// Channel  Dir  Fields                        Beat taken when
// cfg_i    in   index, data                   cfg_i.valid & cfg_i.ready
// pix_i    in   kind, pixel_value             pix_i.valid & pix_i.ready
// res_o    out  smoothed_value, end_of_image  res_o.valid & res_o.ready
//
// One item per cycle sustained while pix_i.ready is high; each result is registered
// in s1, s2 and s3 and is then queued. Results lag their pixel by one row plus one
// column of items. The line store is one dual-port RAM (one read, one write per
// cycle), so each item's column is read and then rewritten once. pix_i.ready drops
// while eight results are reserved but not yet popped from the output queue; cfg_i
// is always ready. Reset needs no clearing pass: stale store entries are never used.
module box_filter_3x3_edge_average import bfa_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfa_cfg_if.sink    cfg_i,
  bfa_in_if.sink     pix_i,
  bfa_out_if.source  res_o
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                       credit_ok, rd_en, s1_valid, reserve, s2_valid;
  logic [COL_W-1:0]           rd_addr, s1_col;
  logic [PIXEL_BITS-1:0]      s1_pix, push_value;
  bfa_tag_t                   s1_tag, s2_tag;
  logic [8:0][PIXEL_BITS-1:0] win;
  logic                       push, push_last;

  // Positions, configuration and item decode
  bfa_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pix_i       (pix_i),
    .credit_ok_i (credit_ok),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_valid_o  (s1_valid),
    .s1_pix_o    (s1_pix),
    .s1_col_o    (s1_col),
    .s1_tag_o    (s1_tag),
    .reserve_o   (reserve)
  );

  // Line store and 3x3 window
  bfa_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .s1_valid_i (s1_valid),
    .s1_pix_i   (s1_pix),
    .s1_col_i   (s1_col),
    .s1_tag_i   (s1_tag),
    .win_o      (win),
    .s2_valid_o (s2_valid),
    .s2_tag_o   (s2_tag)
  );

  // Masked sum and division
  bfa_mean #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_i        (win),
    .s2_valid_i   (s2_valid),
    .s2_tag_i     (s2_tag),
    .push_o       (push),
    .push_value_o (push_value),
    .push_last_o  (push_last)
  );

  // Result queue with credit back to the input
  bfa_ofifo #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ofifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_value_i (push_value),
    .push_last_i  (push_last),
    .reserve_i    (reserve),
    .credit_ok_o  (credit_ok),
    .res_o        (res_o)
  );

endmodule
